// ===== hdl/iqpd_pkg.sv =====
package iqpd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int XY_W     = 35;
    localparam int Z_W      = 32;
    localparam int SUM_W    = 26;
    localparam int DEG_W    = 9;

    localparam int BLOCK_LEN_DEF     = 64;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = DEG_W;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_PHASE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_CAL_ENABLE = 1'b1;

    localparam logic [Z_W-1:0] HALF_TURN_Z = 32'h8000_0000;
    localparam logic [Z_W-1:0] ROUND_Z     = 32'h0000_8000;

    localparam logic [ANGLE_W-1:0] LOCK_SPREAD_MAX = ANGLE_W'(65535 / 72);

    localparam int DEG_NUM_W       = 25;
    localparam int DEG_RECIP_SHIFT = 34;
    localparam int DEG_RECIP_W     = 26;
    localparam logic [DEG_RECIP_W-1:0] DEG_RECIP =
        DEG_RECIP_W'(((64'd1 << DEG_RECIP_SHIFT) + 64'd359) / 64'd360);
    localparam logic [DEG_NUM_W-1:0] DEG_HALF_STEP = DEG_NUM_W'(180);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] chan_a_i;
        logic signed [SAMPLE_W-1:0] chan_a_q;
        logic signed [SAMPLE_W-1:0] chan_b_i;
        logic signed [SAMPLE_W-1:0] chan_b_q;
        logic                       rearm;
    } in_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]  sample_phase;
        logic                block_done;
        logic [ANGLE_W-1:0]  average_phase;
        logic [ANGLE_W-1:0]  phase_correction;
        logic [ANGLE_W-1:0]  phase_spread;
        logic                locked;
        logic                apply_pulse;
        logic [SAMPLE_W-1:0] peak_level;
    } out_word_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x_a;
        logic signed [XY_W-1:0] y_a;
        logic [Z_W-1:0]         z_a;
        logic                   zero_a;
        logic signed [XY_W-1:0] x_b;
        logic signed [XY_W-1:0] y_b;
        logic [Z_W-1:0]         z_b;
        logic                   zero_b;
        logic [SAMPLE_W-1:0]    peak;
        logic                   rearm;
    } cell_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]  diff;
        logic                done;
        logic [SUM_W-1:0]    sum;
        logic [ANGLE_W-1:0]  low;
        logic [ANGLE_W-1:0]  high;
        logic [SAMPLE_W-1:0] peak;
        logic                rearm;
    } stats_word_t;

    function automatic logic [Z_W-1:0] atan_turn(input int k);
        logic [Z_W-1:0] r;
        case (k)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10680350;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/iqpd_cell.sv =====
module iqpd_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  iqpd_pkg::cell_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output iqpd_pkg::cell_word_t out_word
);

    localparam logic [iqpd_pkg::Z_W-1:0] ANGLE_STEP = iqpd_pkg::atan_turn(SHIFT);

    logic                 valid_reg;
    iqpd_pkg::cell_word_t word_reg;
    iqpd_pkg::cell_word_t word_next;
    logic                 pos_a;
    logic                 pos_b;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    assign pos_a = !in_word.y_a[iqpd_pkg::XY_W-1] && (in_word.y_a != '0);
    assign pos_b = !in_word.y_b[iqpd_pkg::XY_W-1] && (in_word.y_b != '0);

    always_comb begin
        word_next = in_word;
        if (pos_a) begin
            word_next.x_a = in_word.x_a + (in_word.y_a >>> SHIFT);
            word_next.y_a = in_word.y_a - (in_word.x_a >>> SHIFT);
            word_next.z_a = in_word.z_a + ANGLE_STEP;
        end else begin
            word_next.x_a = in_word.x_a - (in_word.y_a >>> SHIFT);
            word_next.y_a = in_word.y_a + (in_word.x_a >>> SHIFT);
            word_next.z_a = in_word.z_a - ANGLE_STEP;
        end
        if (pos_b) begin
            word_next.x_b = in_word.x_b + (in_word.y_b >>> SHIFT);
            word_next.y_b = in_word.y_b - (in_word.x_b >>> SHIFT);
            word_next.z_b = in_word.z_b + ANGLE_STEP;
        end else begin
            word_next.x_b = in_word.x_b - (in_word.y_b >>> SHIFT);
            word_next.y_b = in_word.y_b + (in_word.x_b >>> SHIFT);
            word_next.z_b = in_word.z_b - ANGLE_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== hdl/iqpd_stats.sv =====
module iqpd_stats #(
    parameter int BLOCK_LEN = iqpd_pkg::BLOCK_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  iqpd_pkg::cell_word_t  in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output iqpd_pkg::stats_word_t out_word
);

    localparam int CNT_W = $clog2(BLOCK_LEN);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(BLOCK_LEN - 1);

    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [iqpd_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [iqpd_pkg::ANGLE_W-1:0]     low_reg, low_next;
    logic [iqpd_pkg::ANGLE_W-1:0]     high_reg, high_next;
    logic [iqpd_pkg::SAMPLE_W-1:0]    peak_reg, peak_next;
    logic                             valid_reg;
    iqpd_pkg::stats_word_t            word_reg, word_next;

    logic [iqpd_pkg::Z_W-1:0]         round_a, round_b;
    logic [iqpd_pkg::ANGLE_W-1:0]     angle_a, angle_b, diff;
    logic                             done;
    logic                             accept;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign accept    = in_valid && in_ready;

    assign round_a = in_word.z_a + iqpd_pkg::ROUND_Z;
    assign round_b = in_word.z_b + iqpd_pkg::ROUND_Z;
    assign angle_a = in_word.zero_a ? '0 : round_a[iqpd_pkg::Z_W-1 -: iqpd_pkg::ANGLE_W];
    assign angle_b = in_word.zero_b ? '0 : round_b[iqpd_pkg::Z_W-1 -: iqpd_pkg::ANGLE_W];
    assign diff    = angle_a - angle_b;
    assign done    = (count_reg == LAST_COUNT);

    always_comb begin
        word_next.diff  = diff;
        word_next.done  = done;
        word_next.sum   = sum_reg + iqpd_pkg::SUM_W'(diff);
        word_next.low   = (diff < low_reg) ? diff : low_reg;
        word_next.high  = (diff > high_reg) ? diff : high_reg;
        word_next.peak  = (in_word.peak > peak_reg) ? in_word.peak : peak_reg;
        word_next.rearm = in_word.rearm;
        if (done) begin
            count_next = '0;
            sum_next   = '0;
            low_next   = '1;
            high_next  = '0;
            peak_next  = '0;
        end else begin
            count_next = count_reg + 1'b1;
            sum_next   = word_next.sum;
            low_next   = word_next.low;
            high_next  = word_next.high;
            peak_next  = word_next.peak;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            low_reg   <= '1;
            high_reg  <= '0;
            peak_reg  <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                low_reg   <= low_next;
                high_reg  <= high_next;
                peak_reg  <= peak_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== hdl/iqpd_report.sv =====
module iqpd_report #(
    parameter int BLOCK_LEN = iqpd_pkg::BLOCK_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  iqpd_pkg::stats_word_t         in_word,
    input  logic [iqpd_pkg::ANGLE_W-1:0]  req_phase,
    input  logic                          auto_cal,
    output logic                          out_valid,
    input  logic                          out_ready,
    output iqpd_pkg::out_word_t           out_word
);

    localparam int DIV_SHIFT = iqpd_pkg::SUM_W + $clog2(BLOCK_LEN);
    localparam int MULT_W    = iqpd_pkg::SUM_W + 1;
    localparam int PROD_W    = iqpd_pkg::SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

    typedef struct packed {
        logic [iqpd_pkg::ANGLE_W-1:0]  diff;
        logic                          done;
        logic [PROD_W-1:0]             product;
        logic [iqpd_pkg::ANGLE_W-1:0]  spread;
        logic                          lock;
        logic                          pulse;
        logic [iqpd_pkg::SAMPLE_W-1:0] peak;
    } mid_word_t;

    logic                 mid_valid_reg;
    mid_word_t            mid_reg, mid_next;
    logic                 mid_ready;
    logic                 armed_reg, armed_next;
    logic                 armed_now;
    logic                 out_valid_reg;
    iqpd_pkg::out_word_t  out_reg, out_next;
    logic [iqpd_pkg::ANGLE_W-1:0] average;

    assign mid_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mid_valid_reg || mid_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb begin
        armed_now        = armed_reg || in_word.rearm;
        mid_next.diff    = in_word.diff;
        mid_next.done    = in_word.done;
        mid_next.product = PROD_W'(in_word.sum) * PROD_W'(DIV_MULT);
        mid_next.spread  = in_word.high - in_word.low;
        mid_next.lock    = (mid_next.spread != '0) &&
                           (mid_next.spread <= iqpd_pkg::LOCK_SPREAD_MAX);
        mid_next.pulse   = in_word.done && mid_next.lock && auto_cal && armed_now;
        mid_next.peak    = in_word.peak;
        armed_next       = mid_next.pulse ? 1'b0 : armed_now;
    end

    assign average = mid_reg.product[DIV_SHIFT +: iqpd_pkg::ANGLE_W];

    always_comb begin
        out_next.sample_phase     = mid_reg.diff;
        out_next.block_done       = mid_reg.done;
        out_next.average_phase    = '0;
        out_next.phase_correction = '0;
        out_next.phase_spread     = '0;
        out_next.locked           = 1'b0;
        out_next.apply_pulse      = 1'b0;
        out_next.peak_level       = '0;
        if (mid_reg.done) begin
            out_next.average_phase    = average;
            out_next.phase_correction = req_phase - average;
            out_next.phase_spread     = mid_reg.spread;
            out_next.locked           = mid_reg.lock;
            out_next.apply_pulse      = mid_reg.pulse;
            out_next.peak_level       = mid_reg.peak;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            armed_reg     <= 1'b1;
        end else begin
            if (in_ready) begin
                mid_valid_reg <= in_valid;
            end
            if (mid_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
            if (in_valid && in_ready) begin
                armed_reg <= armed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mid_reg <= mid_next;
        end
        if (mid_valid_reg && mid_ready) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/dual_iq_phase_difference_monitor_unit.sv =====
// Phase difference monitor for two I/Q receiver channels.
// The s_ channel takes one word per cycle while s_ready is high, holding an
// I/Q pair for each channel and a rearm bit. The m_ channel returns one word
// for every input word, in order: the per-sample phase difference, and on the
// last word of each block of BLOCK_LEN samples the average, correction,
// spread, lock flag, apply pulse and peak I level. Block fields read zero on
// other words. Each word passes the CORDIC cells, the statistics register and
// the report registers. One word per cycle is sustained while m_ready stays
// high; the CORDIC cells rotate both channels in lockstep, one micro-rotation
// per cell. Every stage has its own valid flag, so bubbles collapse: while
// the receiver stalls, new words are still taken until the pipeline is full,
// and then s_ready falls. No word is lost or repeated under stalls.
// The cfg port writes the required phase in degrees or the auto-calibration
// enable; write it only while the block is idle.
// Reset clears the pipeline, the block statistics and the configuration and
// arms the auto-calibration pulse.
module dual_iq_phase_difference_monitor_unit #(
    parameter int BLOCK_LEN     = iqpd_pkg::BLOCK_LEN_DEF,
    parameter int CORDIC_STAGES = iqpd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  iqpd_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output iqpd_pkg::out_word_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [iqpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [iqpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int XY_W  = iqpd_pkg::XY_W;
    localparam int EXT_W = XY_W - 2 * iqpd_pkg::SAMPLE_W;

    logic [iqpd_pkg::ANGLE_W-1:0] req_phase_reg, req_phase_next;
    logic                         auto_cal_reg, auto_cal_next;

    logic [iqpd_pkg::DEG_W-1:0]          deg_mag;
    logic [iqpd_pkg::DEG_NUM_W-1:0]      deg_num;
    logic [iqpd_pkg::DEG_NUM_W+iqpd_pkg::DEG_RECIP_W-1:0] deg_prod;
    logic [iqpd_pkg::ANGLE_W-1:0]        turn_mag;

    iqpd_pkg::cell_word_t chain_word  [0:CORDIC_STAGES];
    logic                 chain_valid [0:CORDIC_STAGES];
    logic                 chain_ready [0:CORDIC_STAGES];

    logic signed [XY_W-1:0] xa_raw, ya_raw, xb_raw, yb_raw;
    logic [iqpd_pkg::SAMPLE_W-1:0] abs_a, abs_b;

    iqpd_pkg::stats_word_t stats_word;
    logic                  stats_valid;
    logic                  stats_ready;

    always_comb begin
        deg_mag  = cfg_data[iqpd_pkg::DEG_W-1] ? (~cfg_data + 1'b1) : cfg_data;
        deg_num  = {deg_mag[iqpd_pkg::DEG_NUM_W-iqpd_pkg::ANGLE_W-1:0],
                    {iqpd_pkg::ANGLE_W{1'b0}}} + iqpd_pkg::DEG_HALF_STEP;
        deg_prod = (iqpd_pkg::DEG_NUM_W + iqpd_pkg::DEG_RECIP_W)'(deg_num) *
                   (iqpd_pkg::DEG_NUM_W + iqpd_pkg::DEG_RECIP_W)'(iqpd_pkg::DEG_RECIP);
        turn_mag = deg_prod[iqpd_pkg::DEG_RECIP_SHIFT +: iqpd_pkg::ANGLE_W];
        req_phase_next = req_phase_reg;
        auto_cal_next  = auto_cal_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                iqpd_pkg::REG_REQUIRED_PHASE: begin
                    req_phase_next = cfg_data[iqpd_pkg::DEG_W-1] ? (~turn_mag + 1'b1)
                                                                 : turn_mag;
                end
                iqpd_pkg::REG_AUTO_CAL_ENABLE: begin
                    auto_cal_next = cfg_data[0];
                end
                default: begin
                    auto_cal_next = auto_cal_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_phase_reg <= '0;
            auto_cal_reg  <= 1'b0;
        end else begin
            req_phase_reg <= req_phase_next;
            auto_cal_reg  <= auto_cal_next;
        end
    end

    assign xa_raw = {{EXT_W{s_data.chan_a_i[iqpd_pkg::SAMPLE_W-1]}}, s_data.chan_a_i,
                     {iqpd_pkg::SAMPLE_W{1'b0}}};
    assign ya_raw = {{EXT_W{s_data.chan_a_q[iqpd_pkg::SAMPLE_W-1]}}, s_data.chan_a_q,
                     {iqpd_pkg::SAMPLE_W{1'b0}}};
    assign xb_raw = {{EXT_W{s_data.chan_b_i[iqpd_pkg::SAMPLE_W-1]}}, s_data.chan_b_i,
                     {iqpd_pkg::SAMPLE_W{1'b0}}};
    assign yb_raw = {{EXT_W{s_data.chan_b_q[iqpd_pkg::SAMPLE_W-1]}}, s_data.chan_b_q,
                     {iqpd_pkg::SAMPLE_W{1'b0}}};

    assign abs_a = s_data.chan_a_i[iqpd_pkg::SAMPLE_W-1] ? (~s_data.chan_a_i + 1'b1)
                                                         : s_data.chan_a_i;
    assign abs_b = s_data.chan_b_i[iqpd_pkg::SAMPLE_W-1] ? (~s_data.chan_b_i + 1'b1)
                                                         : s_data.chan_b_i;

    always_comb begin
        if (s_data.chan_a_i[iqpd_pkg::SAMPLE_W-1]) begin
            chain_word[0].x_a = -xa_raw;
            chain_word[0].y_a = -ya_raw;
            chain_word[0].z_a = iqpd_pkg::HALF_TURN_Z;
        end else begin
            chain_word[0].x_a = xa_raw;
            chain_word[0].y_a = ya_raw;
            chain_word[0].z_a = '0;
        end
        if (s_data.chan_b_i[iqpd_pkg::SAMPLE_W-1]) begin
            chain_word[0].x_b = -xb_raw;
            chain_word[0].y_b = -yb_raw;
            chain_word[0].z_b = iqpd_pkg::HALF_TURN_Z;
        end else begin
            chain_word[0].x_b = xb_raw;
            chain_word[0].y_b = yb_raw;
            chain_word[0].z_b = '0;
        end
        chain_word[0].zero_a = (s_data.chan_a_i == '0) && (s_data.chan_a_q == '0);
        chain_word[0].zero_b = (s_data.chan_b_i == '0) && (s_data.chan_b_q == '0);
        chain_word[0].peak   = (abs_a > abs_b) ? abs_a : abs_b;
        chain_word[0].rearm  = s_data.rearm;
    end

    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        iqpd_cell #(
            .SHIFT (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_word   (chain_word[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_word  (chain_word[k+1])
        );
    end

    iqpd_stats #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_word   (chain_word[CORDIC_STAGES]),
        .out_valid (stats_valid),
        .out_ready (stats_ready),
        .out_word  (stats_word)
    );

    iqpd_report #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_report (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stats_valid),
        .in_ready  (stats_ready),
        .in_word   (stats_word),
        .req_phase (req_phase_reg),
        .auto_cal  (auto_cal_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_data)
    );

endmodule

// ===== tb/dual_iq_phase_difference_monitor_unit_tb.sv =====
`timescale 1ns / 1ps

module dual_iq_phase_difference_monitor_unit_tb;

    localparam int BLOCK_N          = iqpd_pkg::BLOCK_LEN_DEF;
    localparam int STAGES           = iqpd_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY          = STAGES + 3;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASES           = 6;
    localparam int BLOCKS_PER_PHASE = 1;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    iqpd_pkg::in_word_t               s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    iqpd_pkg::out_word_t              m_data;
    logic                             cfg_wr_en = 1'b0;
    logic [iqpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [iqpd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    bit [31:0] atan_step [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680350, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Mirror of the block's configuration and running block statistics.
    logic [iqpd_pkg::DEG_W-1:0]    req_deg_cfg  = '0;
    logic                          auto_cal_cfg = 1'b0;
    int unsigned                   blk_count    = 0;
    logic [iqpd_pkg::SUM_W-1:0]    blk_sum      = '0;
    logic [iqpd_pkg::ANGLE_W-1:0]  blk_low      = '1;
    logic [iqpd_pkg::ANGLE_W-1:0]  blk_high     = '0;
    logic [iqpd_pkg::SAMPLE_W-1:0] blk_peak     = '0;
    logic                          pulse_armed  = 1'b1;

    iqpd_pkg::in_word_t  stim_words[$];
    iqpd_pkg::out_word_t phase_results_due[$];
    iqpd_pkg::out_word_t want;

    int errors      = 0;
    int blocks_seen = 0;
    int locks_seen  = 0;
    int pulses_seen = 0;
    int words_seen  = 0;
    int cycles      = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit steady_send = 1'b0;
    bit steady_recv = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    dual_iq_phase_difference_monitor_unit #(
        .BLOCK_LEN     (BLOCK_N),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [iqpd_pkg::ANGLE_W-1:0] cordic_angle(
        input logic signed [iqpd_pkg::SAMPLE_W-1:0] i_in,
        input logic signed [iqpd_pkg::SAMPLE_W-1:0] q_in);
        longint    x;
        longint    y;
        longint    nx;
        longint    ny;
        bit [31:0] z;
        bit [31:0] zr;
        if (i_in == 0 && q_in == 0) begin
            return '0;
        end
        if (i_in < 0) begin
            x = -longint'(i_in) * 65536;
            y = -longint'(q_in) * 65536;
            z = 32'h8000_0000;
        end else begin
            x = longint'(i_in) * 65536;
            y = longint'(q_in) * 65536;
            z = '0;
        end
        for (int k = 0; k < STAGES && k < 24; k++) begin
            if (y > 0) begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z  = z + atan_step[k];
            end else begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z  = z - atan_step[k];
            end
            x = nx;
            y = ny;
        end
        zr = z + 32'h0000_8000;
        return zr[31:16];
    endfunction

    function automatic logic [iqpd_pkg::SAMPLE_W-1:0] abs_level(
        input logic signed [iqpd_pkg::SAMPLE_W-1:0] v);
        int m;
        m = (v < 0) ? -int'(v) : int'(v);
        return iqpd_pkg::SAMPLE_W'(m);
    endfunction

    function automatic iqpd_pkg::out_word_t predict_phase_word(input iqpd_pkg::in_word_t w);
        iqpd_pkg::out_word_t           r;
        logic [iqpd_pkg::ANGLE_W-1:0]  diff;
        logic [iqpd_pkg::ANGLE_W-1:0]  avg;
        logic [iqpd_pkg::ANGLE_W-1:0]  spread;
        logic [iqpd_pkg::SAMPLE_W-1:0] pa;
        logic [iqpd_pkg::SAMPLE_W-1:0] pb;
        longint                        deg;
        longint                        mag;
        longint                        req;
        bit                            lock;
        bit                            pulse;
        r = '0;
        if (w.rearm) begin
            pulse_armed = 1'b1;
        end
        diff = cordic_angle(w.chan_a_i, w.chan_a_q) - cordic_angle(w.chan_b_i, w.chan_b_q);
        blk_sum = blk_sum + iqpd_pkg::SUM_W'(diff);
        if (diff < blk_low) begin
            blk_low = diff;
        end
        if (diff > blk_high) begin
            blk_high = diff;
        end
        pa = abs_level(w.chan_a_i);
        pb = abs_level(w.chan_b_i);
        if (pa > blk_peak) begin
            blk_peak = pa;
        end
        if (pb > blk_peak) begin
            blk_peak = pb;
        end
        blk_count = (blk_count + 1) & 32'h7FF;
        r.sample_phase = diff;
        if (blk_count >= BLOCK_N) begin
            avg    = iqpd_pkg::ANGLE_W'(blk_sum / BLOCK_N);
            deg    = longint'($signed(req_deg_cfg));
            mag    = (((deg < 0) ? -deg : deg) * 65536 + 180) / 360;
            req    = (deg < 0) ? -mag : mag;
            spread = (blk_high >= blk_low) ? blk_high - blk_low : '0;
            lock   = (spread != 0) && (int'(spread) * 72 < 65536);
            pulse  = lock && auto_cal_cfg && pulse_armed;
            if (pulse) begin
                pulse_armed = 1'b0;
            end
            r.block_done       = 1'b1;
            r.average_phase    = avg;
            r.phase_correction = iqpd_pkg::ANGLE_W'(req - longint'(avg));
            r.phase_spread     = spread;
            r.locked           = lock;
            r.apply_pulse      = pulse;
            r.peak_level       = blk_peak;
            blk_count = 0;
            blk_sum   = '0;
            blk_low   = '1;
            blk_high  = '0;
            blk_peak  = '0;
        end
        return r;
    endfunction

    function automatic iqpd_pkg::in_word_t iq_word(input int ai, input int aq, input int bi,
                                                   input int bq, input bit rearm);
        iqpd_pkg::in_word_t w;
        w.chan_a_i = iqpd_pkg::SAMPLE_W'(ai);
        w.chan_a_q = iqpd_pkg::SAMPLE_W'(aq);
        w.chan_b_i = iqpd_pkg::SAMPLE_W'(bi);
        w.chan_b_q = iqpd_pkg::SAMPLE_W'(bq);
        w.rearm    = rearm;
        return w;
    endfunction

    function automatic int any_sample();
        case ($urandom_range(0, 15))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int clamp_sample(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32767) begin
            return -32767;
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end
        if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // A tidy block carries channel B as channel A turned by a quarter, half or
    // three quarters of a turn plus a little noise, so the spread stays small
    // enough to lock on most blocks.
    task automatic queue_block(input bit tidy);
        int ai;
        int aq;
        int bi;
        int bq;
        int turn;
        int noise;
        int outlier;
        bit rearm;
        turn = $urandom_range(1, 3);
        case ($urandom_range(0, 4))
            0:       noise = 0;
            1:       noise = 4;
            2:       noise = 64;
            3:       noise = 1500;
            default: noise = 4000;
        endcase
        outlier = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BLOCK_N - 1) : -1;
        for (int k = 0; k < BLOCK_N; k++) begin
            rearm = ($urandom_range(0, 31) == 0) ||
                    (k == BLOCK_N - 1 && $urandom_range(0, 2) == 0);
            if (!tidy || k == outlier) begin
                stim_words.push_back(iq_word(any_sample(), any_sample(), any_sample(),
                                             any_sample(), rearm));
            end else begin
                ai = int'($urandom_range(0, 65534)) - 32767;
                aq = int'($urandom_range(0, 65534)) - 32767;
                case (turn)
                    1: begin
                        bi = -aq;
                        bq = ai;
                    end
                    2: begin
                        bi = -ai;
                        bq = -aq;
                    end
                    default: begin
                        bi = aq;
                        bq = -ai;
                    end
                endcase
                bi = bi + int'($urandom_range(0, 2 * noise)) - noise;
                bq = bq + int'($urandom_range(0, 2 * noise)) - noise;
                stim_words.push_back(iq_word(ai, aq, clamp_sample(bi), clamp_sample(bq),
                                             rearm));
            end
        end
    endtask

    task automatic write_reg(input logic [iqpd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [iqpd_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == iqpd_pkg::REG_REQUIRED_PHASE) begin
            req_deg_cfg = val;
        end else begin
            auto_cal_cfg = val[0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (stim_words.size() != 0 || s_valid || phase_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic note_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                phase_results_due.push_back(predict_phase_word(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (stim_words.size() != 0) begin
                    s_data  <= stim_words.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) begin
                        steady_send = !steady_send;
                    end
                    gap_left = steady_send ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (phase_results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result word with no expectation, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = phase_results_due.pop_front();
                    note_field("sample_phase", want.sample_phase, m_data.sample_phase);
                    note_field("block_done", want.block_done, m_data.block_done);
                    note_field("average_phase", want.average_phase, m_data.average_phase);
                    note_field("phase_correction", want.phase_correction,
                               m_data.phase_correction);
                    note_field("phase_spread", want.phase_spread, m_data.phase_spread);
                    note_field("locked", want.locked, m_data.locked);
                    note_field("apply_pulse", want.apply_pulse, m_data.apply_pulse);
                    note_field("peak_level", want.peak_level, m_data.peak_level);
                    blocks_seen += want.block_done;
                    locks_seen  += want.locked;
                    pulses_seen += want.apply_pulse;
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!steady_recv && $urandom_range(0, 7) == 0) begin
                    stall_left = pick_gap();
                end
                if ($urandom_range(0, 255) == 0) begin
                    steady_recv = !steady_recv;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [iqpd_pkg::DEG_W-1:0] deg;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(iqpd_pkg::REG_REQUIRED_PHASE, iqpd_pkg::DEG_W'(-180));
        write_reg(iqpd_pkg::REG_AUTO_CAL_ENABLE, iqpd_pkg::CFG_DATA_W'(1));

        // Zero vectors, half-turn folding and the sample extremes.
        stim_words.push_back(iq_word(32767, 0, 32767, 0, 1'b0));
        stim_words.push_back(iq_word(-32768, 0, 32767, 0, 1'b0));
        stim_words.push_back(iq_word(0, 0, 0, 0, 1'b0));
        stim_words.push_back(iq_word(0, 0, 12345, -2222, 1'b0));
        stim_words.push_back(iq_word(1000, -3000, 0, 0, 1'b1));
        stim_words.push_back(iq_word(-32768, -32768, 32767, 32767, 1'b0));
        stim_words.push_back(iq_word(32767, -32768, -32768, 32767, 1'b0));
        stim_words.push_back(iq_word(0, 32767, 0, -32768, 1'b0));
        stim_words.push_back(iq_word(-1, 0, 1, 0, 1'b0));
        stim_words.push_back(iq_word(0, -1, 0, 1, 1'b1));
        stim_words.push_back(iq_word(-1, -1, -32768, 1, 1'b0));
        stim_words.push_back(iq_word(32767, 32767, 32767, 32767, 1'b0));
        stim_words.push_back(iq_word(-32768, 32767, -32768, -32767, 1'b1));
        stim_words.push_back(iq_word(1, 1, -1, -1, 1'b0));
        stim_words.push_back(iq_word(0, -32768, -32768, 0, 1'b0));
        stim_words.push_back(iq_word(-32768, 0, 0, -32768, 1'b1));
        while (stim_words.size() < BLOCK_N) begin
            stim_words.push_back(iq_word(any_sample(), any_sample(), any_sample(),
                                         any_sample(), 1'($urandom_range(0, 1))));
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       deg = iqpd_pkg::DEG_W'(0);
                1:       deg = iqpd_pkg::DEG_W'(-256);
                2:       deg = iqpd_pkg::DEG_W'(255);
                3:       deg = iqpd_pkg::DEG_W'(180);
                4:       deg = iqpd_pkg::DEG_W'(-180);
                default: deg = iqpd_pkg::DEG_W'($urandom);
            endcase
            write_reg(iqpd_pkg::REG_REQUIRED_PHASE, deg);
            write_reg(iqpd_pkg::REG_AUTO_CAL_ENABLE, iqpd_pkg::CFG_DATA_W'(ph % 3 != 2));
            for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
                queue_block($urandom_range(0, 3) != 0);
            end
            drain();
        end

        $display("Checked %0d result words over %0d blocks and %0d register settings.",
                 words_seen, blocks_seen, PHASES + 1);
        $display("Blocks locked: %0d, apply pulses: %0d, mismatches: %0d.",
                 locks_seen, pulses_seen, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/iqpd_pkg.sv
hdl/iqpd_cell.sv
hdl/iqpd_stats.sv
hdl/iqpd_report.sv
hdl/dual_iq_phase_difference_monitor_unit.sv
tb/dual_iq_phase_difference_monitor_unit_tb.sv
